>>> sv/dna2aa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// dna2aa_pkg: letter codes, result kinds and the standard codon table
// for the dna to amino acid translator. No dependencies.
package dna2aa_pkg;

    typedef logic [7:0] char_t;

    typedef enum logic [1:0] {
        KIND_CODON = 2'd0,
        KIND_BAD   = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    localparam char_t CHAR_A    = 8'h41;
    localparam char_t CHAR_C    = 8'h43;
    localparam char_t CHAR_G    = 8'h47;
    localparam char_t CHAR_T    = 8'h54;
    localparam char_t CHAR_U    = 8'h55;
    localparam char_t CHAR_BAD  = 8'h3F;
    localparam char_t AMINO_UNK = 8'h5A;

    // index = 16*first + 4*second + third, letters ordered U, C, A, G
    localparam logic [8*64-1:0] CODE_TABLE =
        {"FFLLSSSSYYZZCCZW", "LLLLPPPPHHQQRRRR",
         "IIIMTTTTNNKKSSRR", "VVVVAAAADDEEGGGG"};

    // dna base to mrna letter
    function automatic char_t to_mrna(input char_t base);
        char_t r;
        case (base)
            CHAR_A:  r = CHAR_U;
            CHAR_T:  r = CHAR_A;
            CHAR_C:  r = CHAR_G;
            CHAR_G:  r = CHAR_C;
            default: r = CHAR_BAD;
        endcase
        return r;
    endfunction

    // bit 2 set for a letter outside U, C, A, G
    function automatic logic [2:0] letter_index(input char_t l);
        logic [2:0] r;
        case (l)
            CHAR_U:  r = 3'd0;
            CHAR_G:  r = 3'd3;
            CHAR_A:  r = 3'd2;
            default: r = 3'd4;
        endcase
        if (l == CHAR_C) begin
            r = 3'd1;
        end
        return r;
    endfunction

    function automatic char_t lookup(input char_t a, input char_t b, input char_t c);
        logic [2:0] i;
        logic [2:0] j;
        logic [2:0] k;
        logic [5:0] idx;
        char_t      r;
        i   = letter_index(a);
        j   = letter_index(b);
        k   = letter_index(c);
        idx = {i[1:0], j[1:0], k[1:0]};
        if (i[2] || j[2] || k[2]) begin
            r = AMINO_UNK;
        end else begin
            r = CODE_TABLE[8*(6'd63 - idx) +: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/dna_to_amino_acid_translator.sv
`timescale 1ns / 1ps
`default_nettype none
// dna_to_amino_acid_translator: input register, codon logic, result register.
// Depends on dna2aa_pkg for letter codes and the codon table.
//
// Usage: one ascii dna base per request on s_dna_base, s_strand_end high on
// the last base of a strand. Bases are mapped to mrna letters and every third
// letter completes a codon, reported on the m_ channel with its amino acid.
// A stop or invalid codon gives 'Z' with kind bad and halts the strand until
// its last base; the last base always gives exactly one result (kind end with
// zero letters when no codon completes there).
// m_valid rises when the codon step writes a result into the result register.
// Throughput: one base per cycle unless the receiver stalls, set by the single
// codon step between the input register and the result register; bases that
// give no result still pass through that step.
// Reset (aresetn low, synchronous) empties both registers and starts a new
// strand. When the receiver stalls, the result register holds, the input
// register keeps one more base and s_ready drops after that.
module dna_to_amino_acid_translator
    import dna2aa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_dna_base,
    input  wire logic       s_strand_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_codon_first,
    output logic [7:0]      m_codon_second,
    output logic [7:0]      m_codon_third,
    output logic [7:0]      m_amino_acid,
    output logic [1:0]      m_result_kind,
    output logic            m_last_of_strand
);

    logic  in_valid_reg;
    char_t in_letter_reg;
    logic  in_end_reg;

    char_t held0_reg, held0_next;
    char_t held1_reg, held1_next;
    logic [1:0] pos_reg, pos_next;
    logic  halted_reg, halted_next;

    logic  out_valid_reg;
    char_t out_first_reg, out_first_next;
    char_t out_second_reg, out_second_next;
    char_t out_third_reg, out_third_next;
    char_t out_amino_reg, out_amino_next;
    kind_t out_kind_reg, out_kind_next;
    logic  out_last_reg;
    logic  produce;
    logic  advance;
    char_t amino;

    // the step may run whenever the result slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign amino = lookup(held0_reg, held1_reg, in_letter_reg);

    always_comb begin
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        pos_next        = pos_reg;
        halted_next     = halted_reg;
        out_first_next  = held0_reg;
        out_second_next = held1_reg;
        out_third_next  = in_letter_reg;
        out_amino_next  = amino;
        out_kind_next   = KIND_CODON;
        produce         = 1'b0;
        if (halted_reg || pos_reg < 2'd2) begin
            if (!halted_reg) begin
                if (pos_reg[0]) begin
                    held1_next = in_letter_reg;
                end else begin
                    held0_next = in_letter_reg;
                end
                pos_next = pos_reg + 2'd1;
            end
            out_first_next  = '0;
            out_second_next = '0;
            out_third_next  = '0;
            out_amino_next  = '0;
            out_kind_next   = KIND_END;
            produce         = in_end_reg;
            if (in_end_reg) begin
                pos_next    = 2'd0;
                halted_next = 1'b0;
            end
        end else begin
            produce  = 1'b1;
            pos_next = 2'd0;
            if (amino == AMINO_UNK) begin
                out_kind_next = KIND_BAD;
                halted_next   = !in_end_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
            halted_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                pos_reg       <= pos_next;
                halted_reg    <= halted_next;
                out_valid_reg <= produce;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_letter_reg <= to_mrna(s_dna_base);
            in_end_reg    <= s_strand_end;
        end
        if (advance) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            if (produce) begin
                out_first_reg  <= out_first_next;
                out_second_reg <= out_second_next;
                out_third_reg  <= out_third_next;
                out_amino_reg  <= out_amino_next;
                out_kind_reg   <= out_kind_next;
                out_last_reg   <= in_end_reg;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_codon_first    = out_first_reg;
    assign m_codon_second   = out_second_reg;
    assign m_codon_third    = out_third_reg;
    assign m_amino_acid     = out_amino_reg;
    assign m_result_kind    = out_kind_reg;
    assign m_last_of_strand = out_last_reg;

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for dna_to_amino_acid_translator. It drives
// directed and random strands with random gaps and stalls and checks every
// result against a typed row or its own codon predictor. Depends on dna2aa_pkg and the RTL.
module tb_top;
    import dna2aa_pkg::*;

    typedef struct packed {
        char_t first;
        char_t second;
        char_t third;
        char_t amino;
        kind_t kind;
        logic  last;
    } translation_t;

    typedef struct packed {
        char_t        base;
        logic         strand_end;
        logic         typed_in;
        translation_t result;
    } stim_row_t;

    localparam int    RANDOM_BASES   = 650;
    localparam int    WATCHDOG_LIMIT = 1000;
    localparam int    DRAIN_CYCLES   = 8;
    localparam int    N_DIRECTED     = 23;
    localparam char_t AMINO_MET      = "M";
    localparam char_t LOWER_A        = "a";

    localparam translation_t STRAND_END_RESULT =
        '{8'h00, 8'h00, 8'h00, 8'h00, KIND_END, 1'b1};

    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // strands too short for a codon
        '{CHAR_A, 1'b1, 1'b1, STRAND_END_RESULT},
        '{CHAR_T, 1'b0, 1'b0, '0},
        '{CHAR_C, 1'b1, 1'b1, STRAND_END_RESULT},
        // tac reads as aug, the start codon
        '{CHAR_T, 1'b0, 1'b0, '0},
        '{CHAR_A, 1'b0, 1'b0, '0},
        '{CHAR_C, 1'b0, 1'b1, '{CHAR_A, CHAR_U, CHAR_G, AMINO_MET, KIND_CODON, 1'b0}},
        // att reads as uaa, a stop codon that halts the strand
        '{CHAR_A, 1'b0, 1'b0, '0},
        '{CHAR_T, 1'b0, 1'b0, '0},
        '{CHAR_T, 1'b0, 1'b1, '{CHAR_U, CHAR_A, CHAR_A, AMINO_UNK, KIND_BAD, 1'b0}},
        // halted strand ignores bases until its end
        '{CHAR_G, 1'b0, 1'b0, '0},
        '{LOWER_A, 1'b0, 1'b0, '0},
        '{CHAR_C, 1'b1, 1'b1, STRAND_END_RESULT},
        // invalid base poisons its codon
        '{8'h00, 1'b0, 1'b0, '0},
        '{CHAR_A, 1'b0, 1'b0, '0},
        '{CHAR_A, 1'b0, 1'b1, '{CHAR_BAD, CHAR_U, CHAR_U, AMINO_UNK, KIND_BAD, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, STRAND_END_RESULT},
        // codon completed by the last base
        '{CHAR_A, 1'b0, 1'b0, '0},
        '{CHAR_A, 1'b0, 1'b0, '0},
        '{CHAR_A, 1'b1, 1'b0, '0},
        // leftover base after a codon is dropped
        '{CHAR_G, 1'b0, 1'b0, '0},
        '{CHAR_G, 1'b0, 1'b0, '0},
        '{CHAR_G, 1'b0, 1'b0, '0},
        '{CHAR_C, 1'b1, 1'b1, STRAND_END_RESULT}
    };

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_dna_base   = 8'h00;
    logic        s_strand_end = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_codon_first;
    logic [7:0]  m_codon_second;
    logic [7:0]  m_codon_third;
    logic [7:0]  m_amino_acid;
    logic [1:0]  m_result_kind;
    logic        m_last_of_strand;

    translation_t pending_translations[$];
    int           fail_count  = 0;
    int           bases_sent  = 0;
    int           idle_cycles = 0;
    int           ready_hold  = 0;

    // predictor state for the open codon
    char_t held_letters [2];
    int    held_count  = 0;
    bit    held_halted = 1'b0;

    dna_to_amino_acid_translator u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_dna_base       (s_dna_base),
        .s_strand_end     (s_strand_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_codon_first    (m_codon_first),
        .m_codon_second   (m_codon_second),
        .m_codon_third    (m_codon_third),
        .m_amino_acid     (m_amino_acid),
        .m_result_kind    (m_result_kind),
        .m_last_of_strand (m_last_of_strand)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic char_t mrna_letter(input char_t base);
        char_t letter;
        case (base)
            CHAR_A:  letter = CHAR_U;
            CHAR_T:  letter = CHAR_A;
            CHAR_C:  letter = CHAR_G;
            CHAR_G:  letter = CHAR_C;
            default: letter = CHAR_BAD;
        endcase
        return letter;
    endfunction

    // table order is u, c, a, g
    function automatic int letter_rank(input char_t letter);
        int rank;
        case (letter)
            CHAR_U:  rank = 0;
            CHAR_G:  rank = 3;
            CHAR_A:  rank = 2;
            default: rank = -1;
        endcase
        if (letter == CHAR_C) begin
            rank = 1;
        end
        return rank;
    endfunction

    function automatic char_t amino_of(input char_t a, input char_t b, input char_t c);
        string codes;
        int    ra;
        int    rb;
        int    rc;
        codes = {"FFLLSSSSYYZZCCZW", "LLLLPPPPHHQQRRRR",
                 "IIIMTTTTNNKKSSRR", "VVVVAAAADDEEGGGG"};
        ra = letter_rank(a);
        rb = letter_rank(b);
        rc = letter_rank(c);
        if (ra < 0 || rb < 0 || rc < 0) begin
            return AMINO_UNK;
        end
        return char_t'(codes[16 * ra + 4 * rb + rc]);
    endfunction

    task automatic translate_base(input char_t base, input logic strand_end,
                                  output bit produced, output translation_t res);
        char_t letter;
        letter   = mrna_letter(base);
        produced = 1'b0;
        res      = '0;
        if (held_halted || held_count < 2) begin
            if (!held_halted) begin
                held_letters[held_count] = letter;
                held_count++;
            end
            if (strand_end) begin
                produced    = 1'b1;
                res         = STRAND_END_RESULT;
                held_count  = 0;
                held_halted = 1'b0;
            end
        end else begin
            produced    = 1'b1;
            res.first   = held_letters[0];
            res.second  = held_letters[1];
            res.third   = letter;
            res.amino   = amino_of(held_letters[0], held_letters[1], letter);
            res.kind    = (res.amino == AMINO_UNK) ? KIND_BAD : KIND_CODON;
            res.last    = strand_end;
            held_count  = 0;
            held_halted = (res.amino == AMINO_UNK) && !strand_end;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    function automatic char_t pick_base(input int bad_pct);
        char_t base;
        if ($urandom_range(0, 99) < bad_pct) begin
            base = char_t'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 3))
                0:       base = CHAR_A;
                1:       base = CHAR_C;
                2:       base = CHAR_G;
                default: base = CHAR_T;
            endcase
        end
        return base;
    endfunction

    // drive one request, wait for it to be taken, then predict its result
    task automatic send_base(input char_t base, input logic strand_end,
                             input logic typed_in, input translation_t typed_result,
                             input bit no_gaps);
        int           gap;
        bit           produced;
        translation_t predicted;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_dna_base   <= base;
        s_strand_end <= strand_end;
        do @(posedge aclk); while (!s_ready);
        translate_base(base, strand_end, produced, predicted);
        if (typed_in) begin
            pending_translations.push_back(typed_result);
        end else if (produced) begin
            pending_translations.push_back(predicted);
        end
        bases_sent++;
    endtask

    task automatic note_failure(input string what, input translation_t want,
                                input translation_t got);
        fail_count++;
        if (fail_count <= 10) begin
            $display({"%s: expected %h %h %h aa %h kind %0d last %0d, ",
                      "got %h %h %h aa %h kind %0d last %0d"},
                     what, want.first, want.second, want.third, want.amino, want.kind,
                     want.last, got.first, got.second, got.third, got.amino, got.kind,
                     got.last);
        end
    endtask

    // receiver: ready and stall stretches of random length
    always @(posedge aclk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 30);
            end else if (r < 75) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else if (r < 90) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(3, 24);
            end else begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(50, 150);
            end
        end
    end

    always @(posedge aclk) begin
        translation_t got;
        translation_t want;
        if (aresetn && m_valid && m_ready) begin
            got.first  = m_codon_first;
            got.second = m_codon_second;
            got.third  = m_codon_third;
            got.amino  = m_amino_acid;
            got.kind   = kind_t'(m_result_kind);
            got.last   = m_last_of_strand;
            if (pending_translations.size() == 0) begin
                note_failure("unexpected result", '0, got);
            end else begin
                want = pending_translations.pop_front();
                if (got.first !== want.first || got.second !== want.second ||
                    got.third !== want.third || got.amino !== want.amino ||
                    got.kind !== want.kind || got.last !== want.last) begin
                    note_failure("result mismatch", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int r;
        int len;
        int bad_pct;
        bit no_gaps;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            send_base(DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].strand_end,
                      DIRECTED_ROWS[i].typed_in, DIRECTED_ROWS[i].result, 1'b0);
        end

        bases_sent = 0;
        while (bases_sent < RANDOM_BASES) begin
            r       = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 4) == 0);
            if (r < 75) begin
                // well-formed strand, rare bad base
                len     = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 60)
                                                      : $urandom_range(3, 24);
                bad_pct = 2;
            end else if (r < 85) begin
                len     = $urandom_range(1, 2);
                bad_pct = 10;
            end else begin
                len     = $urandom_range(1, 12);
                bad_pct = 100;
            end
            for (int i = 0; i < len; i++) begin
                send_base(pick_base(bad_pct), i == len - 1, 1'b0, '0, no_gaps);
            end
        end
        s_valid <= 1'b0;

        while (pending_translations.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
